>>> rtl/core/tlb_page_translation_unit_core_assert.svh
// Assertion macros for the translation unit
`ifndef TLB_PAGE_TRANSLATION_UNIT_CORE_ASSERT_SVH
`define TLB_PAGE_TRANSLATION_UNIT_CORE_ASSERT_SVH
`define TPTU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TPTU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/core/tptu_pkg.sv
// Shared types and constants for the translation unit
package tptu_pkg;
   localparam logic [2:0] OP_TRANSLATE = 3'd0;
   localparam logic [2:0] OP_MAP       = 3'd1;
   localparam logic [2:0] OP_UNMAP     = 3'd2;
   localparam logic [2:0] OP_SWITCH    = 3'd3;
   localparam logic [2:0] OP_INSP_TLB  = 3'd4;
   localparam logic [2:0] OP_INSP_PT   = 3'd5;
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FAULT = 2'd1;
   localparam logic [1:0] ST_BADID = 2'd2;
   localparam logic [1:0] CSR_OFFSET = 2'd0;
   localparam logic [1:0] CSR_PAGE   = 2'd1;
   localparam logic [1:0] CSR_POLICY = 2'd2;
   typedef struct packed {
      logic [2:0]  opcode;
      logic [13:0] virtual_address;
      logic [5:0]  page_number;
      logic [7:0]  frame_in;
      logic [2:0]  new_process;
      logic [2:0]  slot_select;
   } req_type;
   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [2:0]  slot_used;
      logic [15:0] phys_addr;
      logic [7:0]  frame_out;
      logic        entry_valid;
      logic [5:0]  entry_page;
      logic [1:0]  entry_owner;
      logic [31:0] entry_stamp;
      logic [1:0]  active_process;
   } rsp_type;
   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_CLEAR} state_type;
endpackage

>>> rtl/core/tptu_page_table.sv
// Page table memory: valid bit and frame per entry, registered read
module tptu_page_table #(
   parameter int ADDR_BITS = 8,
   parameter int FRAME_BITS = 8
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic                  rd_valid,
   output logic [FRAME_BITS-1:0] rd_frame,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic                  wr_valid,
   input  logic [FRAME_BITS-1:0] wr_frame
);
   logic [FRAME_BITS:0] mem_ff [2**ADDR_BITS];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= {wr_valid, wr_frame};
      if (rd_en) {rd_valid, rd_frame} <= mem_ff[rd_addr];
   end
endmodule

>>> rtl/core/tlb_page_translation_unit_core.sv
// Translation unit top level: TLB in flops, page table in a synchronous memory.
// Usage: pulse start with req holding one operation while busy is low. The
// result is computed in the execute state and registered onto rsp, shown for
// exactly one cycle with rsp_strobe. Each item first issues the page-table read
// and advances the tick in the idle state, then compares the TLB, uses the read
// data, updates the TLB and writes back in the execute state. busy is high in
// the execute state, so a new item is not accepted until the current one is done.
// After reset the unit sweeps the page table to clear it, one entry a cycle,
// over all PROCESS_COUNT * 2**MAX_PAGE_BITS entries (256 by default), with busy high.
// Configuration writes through csr_* take effect at once and are accepted at
// any time; write them only while idle. The TLB valid bits, process id, FIFO
// pointer and tick clear in the reset cycle.
// The receiver cannot stall: results are presented once and not held.
// Operations 6 and 7 only advance the tick and return status ok.
module tlb_page_translation_unit_core #(
   parameter int TLB_SLOTS = 8,
   parameter int PROCESS_COUNT = 4,
   parameter int MAX_PAGE_BITS = 6,
   parameter int FRAME_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  tptu_pkg::req_type   req_data,
   output logic                rsp_strobe,
   output tptu_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [3:0]          csr_wdata
);
`include "tlb_page_translation_unit_core_assert.svh"
   localparam int SB = $clog2(TLB_SLOTS);
   localparam int PB = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
   localparam int AB = PB + MAX_PAGE_BITS;
   localparam int DEPTH = PROCESS_COUNT * (2**MAX_PAGE_BITS);

   logic [3:0] offset_bits_ff;
   logic [2:0] page_bits_ff;
   logic       policy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= 4'd4; page_bits_ff <= 3'd6; policy_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            tptu_pkg::CSR_OFFSET: offset_bits_ff <= csr_wdata;
            tptu_pkg::CSR_PAGE:   page_bits_ff   <= csr_wdata[2:0];
            tptu_pkg::CSR_POLICY: policy_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   tptu_pkg::state_type state_ff, state_in;
   logic [AB:0] clr_ff, clr_in;
   tptu_pkg::req_type req_ff, req_in;
   logic [31:0] tick_ff, tick_in;
   logic [PB-1:0] proc_ff, proc_in;
   logic [SB-1:0] fifo_ff, fifo_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   tptu_pkg::rsp_type rsp_ff, rsp_in;

   logic               sv_ff [TLB_SLOTS];
   logic [PB-1:0]      so_ff [TLB_SLOTS];
   logic [MAX_PAGE_BITS-1:0] sp_ff [TLB_SLOTS];
   logic [FRAME_BITS-1:0] sf_ff [TLB_SLOTS];
   logic [31:0]        ss_ff [TLB_SLOTS];

   // page mask from saturated page bit count
   logic [3:0] pbits;
   logic [MAX_PAGE_BITS-1:0] pmask, page_tr, page_op, page_sel;
   logic [13:0] va_sh;
   always_comb begin
      pbits = (32'(page_bits_ff) > MAX_PAGE_BITS) ? 4'(MAX_PAGE_BITS) : {1'b0, page_bits_ff};
      pmask = MAX_PAGE_BITS'((32'd1 << pbits) - 32'd1);
      va_sh = req_ff.virtual_address >> offset_bits_ff;
      page_tr = MAX_PAGE_BITS'(32'(va_sh)) & pmask;
      page_op = MAX_PAGE_BITS'(32'(req_ff.page_number)) & pmask;
      page_sel = (req_ff.opcode == tptu_pkg::OP_TRANSLATE) ? page_tr : page_op;
   end

   // page table address is formed from the incoming request
   logic [13:0] va_shi;
   logic [MAX_PAGE_BITS-1:0] pg_i;
   logic [AB-1:0] rd_addr;
   always_comb begin
      va_shi = req_data.virtual_address >> offset_bits_ff;
      pg_i = (req_data.opcode == tptu_pkg::OP_TRANSLATE) ?
             (MAX_PAGE_BITS'(32'(va_shi)) & pmask) :
             (MAX_PAGE_BITS'(32'(req_data.page_number)) & pmask);
      rd_addr = {proc_ff, pg_i};
   end

   logic pt_valid;
   logic [FRAME_BITS-1:0] pt_frame;
   logic wr_en, wr_v;
   logic [AB-1:0] wr_addr;
   logic [FRAME_BITS-1:0] wr_f, frame_req;
   logic accept;
   assign accept = start && !busy;
   assign frame_req = FRAME_BITS'(32'(req_ff.frame_in));

   tptu_page_table #(.ADDR_BITS(AB), .FRAME_BITS(FRAME_BITS)) u_pt (
      .clock(clock), .rd_en(accept), .rd_addr(rd_addr),
      .rd_valid(pt_valid), .rd_frame(pt_frame),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_valid(wr_v), .wr_frame(wr_f));

   // TLB search
   logic match_f, inv_f;
   logic [SB-1:0] match_s, inv_s, old_s, victim_s;
   always_comb begin
      match_f = 1'b0; match_s = '0; inv_f = 1'b0; inv_s = '0; old_s = '0;
      for (int i = TLB_SLOTS-1; i >= 0; i--) begin
         if (sv_ff[i] && so_ff[i] == proc_ff && sp_ff[i] == page_sel) begin
            match_f = 1'b1; match_s = SB'(i);
         end
         if (!sv_ff[i]) begin
            inv_f = 1'b1; inv_s = SB'(i);
         end
      end
      for (int i = 1; i < TLB_SLOTS; i++)
         if (ss_ff[i] < ss_ff[old_s]) old_s = SB'(i);
   end

   logic do_fill, do_hit, do_inv;
   logic [FRAME_BITS-1:0] fill_frame;
   logic [SB-1:0] ins;
   logic [15:0] pa;
   logic [31:0] pa_w;
   always_comb begin
      state_in = state_ff; clr_in = clr_ff; req_in = req_ff;
      tick_in = tick_ff; proc_in = proc_ff; fifo_in = fifo_ff;
      rsp_strobe_in = 1'b0; rsp_in = rsp_ff;
      wr_en = 1'b0; wr_addr = {proc_ff, page_sel}; wr_v = 1'b0; wr_f = '0;
      do_fill = 1'b0; do_hit = 1'b0; do_inv = 1'b0; fill_frame = '0; victim_s = '0;
      ins = SB'(32'(req_ff.slot_select) % TLB_SLOTS);
      pa_w = '0; pa = '0;
      busy = 1'b1;
      case (state_ff)
         tptu_pkg::S_CLEAR: begin
            wr_en = 1'b1; wr_addr = clr_ff[AB-1:0];
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == DEPTH-1) state_in = tptu_pkg::S_IDLE;
         end
         tptu_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               req_in = req_data; tick_in = tick_ff + 32'd1;
               state_in = tptu_pkg::S_EXEC;
            end
         end
         tptu_pkg::S_EXEC: begin
            state_in = tptu_pkg::S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_in = '0;
            case (req_ff.opcode)
               tptu_pkg::OP_TRANSLATE: begin
                  if (match_f) begin
                     do_hit = 1'b1; victim_s = match_s; fill_frame = sf_ff[match_s];
                     rsp_in.hit = 1'b1;
                  end else if (!pt_valid) begin
                     rsp_in.status = tptu_pkg::ST_FAULT;
                  end else begin
                     do_fill = 1'b1; fill_frame = pt_frame;
                     if (!policy_ff) begin
                        victim_s = fifo_ff;
                        fifo_in = SB'((32'(fifo_ff) + 1) % TLB_SLOTS);
                     end else victim_s = inv_f ? inv_s : old_s;
                  end
                  if (match_f || pt_valid) begin
                     pa_w = (32'(fill_frame) << offset_bits_ff) |
                            (32'(req_ff.virtual_address) &
                             ((32'd1 << offset_bits_ff) - 32'd1));
                     pa = pa_w[15:0];
                     rsp_in.slot_used = 3'(victim_s);
                     rsp_in.phys_addr = pa;
                     rsp_in.frame_out = 8'(fill_frame);
                  end
               end
               tptu_pkg::OP_MAP: begin
                  wr_en = 1'b1; wr_v = 1'b1; wr_f = frame_req;
                  fill_frame = frame_req;
                  if (match_f) begin
                     do_hit = 1'b1; victim_s = match_s;
                  end else begin
                     do_fill = 1'b1;
                     if (inv_f) victim_s = inv_s;
                     else if (!policy_ff) begin
                        victim_s = fifo_ff;
                        fifo_in = SB'((32'(fifo_ff) + 1) % TLB_SLOTS);
                     end else victim_s = old_s;
                  end
                  rsp_in.slot_used = 3'(victim_s);
                  rsp_in.frame_out = 8'(frame_req);
               end
               tptu_pkg::OP_UNMAP: begin
                  wr_en = 1'b1;
                  do_inv = match_f; victim_s = match_s;
               end
               tptu_pkg::OP_SWITCH: begin
                  if (32'(req_ff.new_process) >= PROCESS_COUNT)
                     rsp_in.status = tptu_pkg::ST_BADID;
                  else proc_in = PB'(req_ff.new_process);
               end
               tptu_pkg::OP_INSP_TLB: begin
                  rsp_in.slot_used = 3'(ins);
                  rsp_in.frame_out = 8'(sf_ff[ins]);
                  rsp_in.entry_valid = sv_ff[ins];
                  rsp_in.entry_page = 6'(sp_ff[ins]);
                  rsp_in.entry_owner = 2'(so_ff[ins]);
                  rsp_in.entry_stamp = ss_ff[ins];
               end
               tptu_pkg::OP_INSP_PT: begin
                  rsp_in.frame_out = 8'(pt_frame);
                  rsp_in.entry_valid = pt_valid;
               end
               default: ;
            endcase
            rsp_in.active_process = 2'(proc_in);
         end
         default: state_in = tptu_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tptu_pkg::S_CLEAR; clr_ff <= '0; tick_ff <= '0;
         proc_ff <= '0; fifo_ff <= '0; rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < TLB_SLOTS; i++) begin
            sv_ff[i] <= 1'b0; so_ff[i] <= '0; sp_ff[i] <= '0;
            sf_ff[i] <= '0; ss_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; tick_ff <= tick_in;
         proc_ff <= proc_in; fifo_ff <= fifo_in; rsp_strobe_ff <= rsp_strobe_in;
         if (do_fill) begin
            sv_ff[victim_s] <= 1'b1; so_ff[victim_s] <= proc_ff;
            sp_ff[victim_s] <= page_sel; sf_ff[victim_s] <= fill_frame;
            ss_ff[victim_s] <= tick_ff;
         end else if (do_hit) begin
            ss_ff[victim_s] <= tick_ff;
            sf_ff[victim_s] <= fill_frame;
         end else if (do_inv) begin
            sv_ff[victim_s] <= 1'b0; sf_ff[victim_s] <= '0;
         end
      end
   end
   always_ff @(posedge clock) begin
      req_ff <= req_in; rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

   `TPTU_ASSERT_NEXT(a_rsp_after_accept, clock, reset, accept, busy ##1 rsp_strobe)
   `TPTU_ASSERT_IMPL(a_no_rsp_busy, clock, reset, rsp_strobe, !busy)
   `TPTU_ASSERT_NEXT(a_tick_step, clock, reset, accept, tick_ff == $past(tick_ff) + 32'd1)
   `TPTU_ASSERT_IMPL(a_clear_no_rsp, clock, reset, state_ff == tptu_pkg::S_CLEAR, !rsp_strobe)
endmodule
